// File: rtl/core/rcs_pkg.sv
// Shared widths, codes and types for the region colour statistics core.
package rcs_pkg;

  localparam int COORD_BITS   = 12;
  localparam int SIZE_BITS    = COORD_BITS + 1;
  localparam int PIX_BITS     = 8;
  localparam int CHANNELS     = 3;
  localparam int CHAN_BITS    = $clog2(CHANNELS);
  localparam int FRAC_BITS    = 8;
  localparam int CAP_BIT      = 2 * COORD_BITS;
  localparam int COUNT_BITS   = CAP_BIT + 1;
  localparam int SUM_BITS     = 32;
  localparam int SQ_BITS      = 40;
  localparam int PROD_BITS    = 64;
  localparam int DEN_BITS     = 48;
  localparam int DIV_NUM_BITS = PROD_BITS + 2 * FRAC_BITS;
  localparam int QUO_BITS     = 16 + 2 * FRAC_BITS;
  localparam int ROOT_BITS    = QUO_BITS / 2;
  localparam int OUT_BITS     = 16;

  localparam int MUL_STEPS  = SQ_BITS;
  localparam int DIV_STEPS  = DIV_NUM_BITS;
  localparam int SQRT_STEPS = ROOT_BITS;
  localparam int STEP_BITS  = $clog2(DIV_STEPS);

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = SIZE_BITS;
  localparam int IN_DATA_BITS   = ((2 * COORD_BITS + 3 * PIX_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS  = 128;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_LEFT   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_TOP    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_HEIGHT = 3'd3;

  typedef logic [3:0] op_t;

  localparam op_t OP_IDLE         = 4'd0;
  localparam op_t OP_MUL_NN1_LD   = 4'd1;
  localparam op_t OP_MUL_NSQ_LD   = 4'd2;
  localparam op_t OP_MUL_SUMSQ_LD = 4'd3;
  localparam op_t OP_MUL_STEP     = 4'd4;
  localparam op_t OP_CAP_NN1      = 4'd5;
  localparam op_t OP_CAP_P1       = 4'd6;
  localparam op_t OP_CAP_D        = 4'd7;
  localparam op_t OP_DIV_MEAN_LD  = 4'd8;
  localparam op_t OP_DIV_DEV_LD   = 4'd9;
  localparam op_t OP_DIV_STEP     = 4'd10;
  localparam op_t OP_CAP_MEAN     = 4'd11;
  localparam op_t OP_SQRT_LD      = 4'd12;
  localparam op_t OP_SQRT_STEP    = 4'd13;
  localparam op_t OP_CAP_DEV      = 4'd14;
  localparam op_t OP_OUT_LOAD     = 4'd15;

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic [PIX_BITS-1:0]   blue;
    logic [PIX_BITS-1:0]   green;
    logic [PIX_BITS-1:0]   red;
  } pixel_t;

  typedef struct packed {
    logic                 acc_en;
    op_t                  op;
    logic [CHAN_BITS-1:0] chan;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

// File: rtl/core/rcs_ctrl.sv
// Sequencer for pixel intake and the per-frame multiply, divide and root passes.
module rcs_ctrl
  import rcs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  input  logic  s_tlast,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_CAP  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [2:0] PH_NN1   = 3'd0;
  localparam logic [2:0] PH_NSQ   = 3'd1;
  localparam logic [2:0] PH_SUMSQ = 3'd2;
  localparam logic [2:0] PH_MEAN  = 3'd3;
  localparam logic [2:0] PH_DEV   = 3'd4;
  localparam logic [2:0] PH_SQRT  = 3'd5;

  logic [2:0]           state, state_next;
  logic [2:0]           phase, phase_next;
  logic [CHAN_BITS-1:0] chan, chan_next;
  logic [STEP_BITS-1:0] step_cnt, step_cnt_next;

  op_t                  load_op, step_op, cap_op;
  logic [STEP_BITS-1:0] step_last;

  always_comb begin
    unique case (phase)
      PH_NN1: begin
        load_op = OP_MUL_NN1_LD; step_op = OP_MUL_STEP; cap_op = OP_CAP_NN1;
        step_last = STEP_BITS'(MUL_STEPS - 1);
      end
      PH_NSQ: begin
        load_op = OP_MUL_NSQ_LD; step_op = OP_MUL_STEP; cap_op = OP_CAP_P1;
        step_last = STEP_BITS'(MUL_STEPS - 1);
      end
      PH_SUMSQ: begin
        load_op = OP_MUL_SUMSQ_LD; step_op = OP_MUL_STEP; cap_op = OP_CAP_D;
        step_last = STEP_BITS'(MUL_STEPS - 1);
      end
      PH_MEAN: begin
        load_op = OP_DIV_MEAN_LD; step_op = OP_DIV_STEP; cap_op = OP_CAP_MEAN;
        step_last = STEP_BITS'(DIV_STEPS - 1);
      end
      PH_DEV: begin
        load_op = OP_DIV_DEV_LD; step_op = OP_DIV_STEP; cap_op = OP_IDLE;
        step_last = STEP_BITS'(DIV_STEPS - 1);
      end
      PH_SQRT: begin
        load_op = OP_SQRT_LD; step_op = OP_SQRT_STEP; cap_op = OP_CAP_DEV;
        step_last = STEP_BITS'(SQRT_STEPS - 1);
      end
      default: begin
        load_op = OP_IDLE; step_op = OP_IDLE; cap_op = OP_IDLE;
        step_last = '0;
      end
    endcase
  end

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    chan_next     = chan;
    step_cnt_next = step_cnt;
    s_tready      = 1'b0;
    cmd.acc_en    = 1'b0;
    cmd.op        = OP_IDLE;
    cmd.chan      = chan;
    unique case (state)
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.acc_en = s_tvalid;
        if (s_tvalid && s_tlast) begin
          state_next = S_LOAD;
          phase_next = PH_NN1;
          chan_next  = '0;
        end
      end
      S_LOAD: begin
        cmd.op        = load_op;
        step_cnt_next = '0;
        state_next    = S_STEP;
      end
      S_STEP: begin
        cmd.op        = step_op;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == step_last) begin
          state_next = S_CAP;
        end
      end
      S_CAP: begin
        cmd.op     = cap_op;
        state_next = S_LOAD;
        unique case (phase)
          PH_NN1:   phase_next = PH_NSQ;
          PH_NSQ:   phase_next = PH_SUMSQ;
          PH_SUMSQ: phase_next = PH_MEAN;
          PH_MEAN:  phase_next = PH_DEV;
          PH_DEV:   phase_next = PH_SQRT;
          default: begin
            if (chan == CHAN_BITS'(CHANNELS - 1)) begin
              state_next = S_OUT;
            end else begin
              chan_next  = chan + 1'b1;
              phase_next = PH_NSQ;
            end
          end
        endcase
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.op     = OP_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_NN1;
      chan     <= '0;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      chan     <= chan_next;
      step_cnt <= step_cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT_LOAD |-> !stat.out_busy)
    else $error("result loaded over a pending item");

  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> (state == S_LOAD && phase == PH_NN1 && chan == '0))
    else $error("frame end did not start the statistics pass");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_STEP |-> step_cnt <= step_last)
    else $error("step counter ran past its pass");

  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT_LOAD |=> (state == S_IDLE && s_tready))
    else $error("not back to intake after result load");
`endif

endmodule

// File: rtl/core/rcs_datapath.sv
// Box test, accumulators, shift-add multiplier, long divider, square root and result register.
module rcs_datapath
  import rcs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  pixel_t                    pix,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  input  logic                      m_tready,
  output logic                      out_valid,
  output logic [OUT_BITS-1:0]       out_mean [CHANNELS],
  output logic [OUT_BITS-1:0]       out_dev [CHANNELS],
  output logic [COUNT_BITS-1:0]     out_count,
  output logic                      out_empty
);

  logic [COORD_BITS-1:0] box_left, box_top;
  logic [SIZE_BITS-1:0]  box_width, box_height;

  logic [SUM_BITS-1:0]   sum [CHANNELS];
  logic [SQ_BITS-1:0]    sq [CHANNELS];
  logic [COUNT_BITS-1:0] count;

  logic [PROD_BITS-1:0]  mul_a, prod, p1, d;
  logic [SQ_BITS-1:0]    mul_b;
  logic [DEN_BITS-1:0]   nn1, div_den, div_rem;
  logic [DIV_NUM_BITS-1:0] div_num;
  logic [QUO_BITS-1:0]   quo, sq_x;
  logic [ROOT_BITS+1:0]  sq_rem;
  logic [ROOT_BITS-1:0]  root;
  logic [OUT_BITS-1:0]   mean_r [CHANNELS];
  logic [OUT_BITS-1:0]   dev_r [CHANNELS];

  logic [PIX_BITS-1:0]   px [CHANNELS];
  logic [2*PIX_BITS-1:0] px_sq [CHANNELS];
  logic [SIZE_BITS:0]    col_end, row_end;
  logic                  in_rect;
  logic [DEN_BITS:0]     rem_sh;
  logic                  div_ge;
  logic [ROOT_BITS+2:0]  sqrt_sh, sqrt_trial;
  logic                  sqrt_ge;

  assign px[0] = pix.blue;
  assign px[1] = pix.green;
  assign px[2] = pix.red;

  assign px_sq[0] = px[0] * px[0];
  assign px_sq[1] = px[1] * px[1];
  assign px_sq[2] = px[2] * px[2];

  assign col_end = (SIZE_BITS + 1)'(box_left) + (SIZE_BITS + 1)'(box_width);
  assign row_end = (SIZE_BITS + 1)'(box_top) + (SIZE_BITS + 1)'(box_height);
  assign in_rect = (pix.column >= box_left) && ((SIZE_BITS + 1)'(pix.column) < col_end) &&
                   (pix.row >= box_top) && ((SIZE_BITS + 1)'(pix.row) < row_end);

  assign rem_sh = {div_rem, div_num[DIV_NUM_BITS-1]};
  assign div_ge = rem_sh >= {1'b0, div_den};

  assign sqrt_sh    = {sq_rem[ROOT_BITS:0], sq_x[QUO_BITS-1 -: 2]};
  assign sqrt_trial = (ROOT_BITS + 3)'({root, 2'b01});
  assign sqrt_ge    = sqrt_sh >= sqrt_trial;

  assign stat.out_busy = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_left   <= '0;
      box_top    <= '0;
      box_width  <= '0;
      box_height <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BOX_LEFT:   box_left   <= cfg_data[COORD_BITS-1:0];
        REG_BOX_TOP:    box_top    <= cfg_data[COORD_BITS-1:0];
        REG_BOX_WIDTH:  box_width  <= cfg_data;
        REG_BOX_HEIGHT: box_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // count stops at the cap so no sum can wrap
  always_ff @(posedge clk) begin
    if (rst || cmd.op == OP_OUT_LOAD) begin
      count <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        sum[c] <= '0;
        sq[c]  <= '0;
      end
    end else if (cmd.acc_en && in_rect && !count[CAP_BIT]) begin
      count <= count + 1'b1;
      for (int c = 0; c < CHANNELS; c++) begin
        sum[c] <= sum[c] + SUM_BITS'(px[c]);
        sq[c]  <= sq[c] + SQ_BITS'(px_sq[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_MUL_NN1_LD: begin
        mul_a <= PROD_BITS'(count);
        mul_b <= SQ_BITS'(count - 1'b1);
        prod  <= '0;
      end
      OP_MUL_NSQ_LD: begin
        mul_a <= PROD_BITS'(sq[cmd.chan]);
        mul_b <= SQ_BITS'(count);
        prod  <= '0;
      end
      OP_MUL_SUMSQ_LD: begin
        mul_a <= PROD_BITS'(sum[cmd.chan]);
        mul_b <= SQ_BITS'(sum[cmd.chan]);
        prod  <= '0;
      end
      OP_MUL_STEP: begin
        if (mul_b[0]) prod <= prod + mul_a;
        mul_a <= mul_a << 1;
        mul_b <= mul_b >> 1;
      end
      OP_CAP_NN1: nn1 <= prod[DEN_BITS-1:0];
      OP_CAP_P1:  p1  <= prod;
      OP_CAP_D:   d   <= p1 - prod;
      OP_DIV_MEAN_LD: begin
        div_num <= DIV_NUM_BITS'({sum[cmd.chan], {FRAC_BITS{1'b0}}});
        div_den <= DEN_BITS'(count);
        div_rem <= '0;
        quo     <= '0;
      end
      OP_DIV_DEV_LD: begin
        div_num <= {d, {(2 * FRAC_BITS){1'b0}}};
        div_den <= nn1;
        div_rem <= '0;
        quo     <= '0;
      end
      OP_DIV_STEP: begin
        div_rem <= div_ge ? DEN_BITS'(rem_sh - {1'b0, div_den}) : DEN_BITS'(rem_sh);
        div_num <= div_num << 1;
        quo     <= {quo[QUO_BITS-2:0], div_ge};
      end
      OP_CAP_MEAN: mean_r[cmd.chan] <= OUT_BITS'(quo);
      OP_SQRT_LD: begin
        sq_x   <= quo;
        sq_rem <= '0;
        root   <= '0;
      end
      OP_SQRT_STEP: begin
        sq_rem <= sqrt_ge ? (ROOT_BITS + 2)'(sqrt_sh - sqrt_trial) : (ROOT_BITS + 2)'(sqrt_sh);
        root   <= {root[ROOT_BITS-2:0], sqrt_ge};
        sq_x   <= sq_x << 2;
      end
      OP_CAP_DEV: dev_r[cmd.chan] <= OUT_BITS'(root);
      OP_OUT_LOAD: begin
        out_count <= count;
        out_empty <= (count == '0);
        for (int c = 0; c < CHANNELS; c++) begin
          out_mean[c] <= (count == '0) ? '0 : mean_r[c];
          out_dev[c]  <= (count <= COUNT_BITS'(1)) ? '0 : dev_r[c];
        end
      end
      OP_IDLE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT_LOAD) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/region_color_statistics_core.sv
// Region colour statistics: per-channel mean and sample deviation over a box.
// Pixels are taken one per cycle; a pixel with s_tlast set ends the frame and
// starts the statistics pass, and m_tvalid rises once the pass and the result load
// are done (later if the previous result is still held). No pixel is taken meanwhile.
// The pass time is set by the shift-add multiplier, long divider and root unit.
// rst is synchronous: box registers and accumulators clear, no result pending.
module region_color_statistics_core
  import rcs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // column, row, blue, green, red
  input  logic [IN_DATA_BITS-1:0]   s_tdata,
  input  logic                      s_tlast,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // mean_blue, mean_green, mean_red, dev_blue, dev_green, dev_red, pixel_count
  output logic [OUT_DATA_BITS-1:0]  m_tdata,
  // region_empty
  output logic                      m_tuser
);

  pixel_t                pix;
  cmd_t                  cmd;
  stat_t                 stat;
  logic [OUT_BITS-1:0]   out_mean [CHANNELS];
  logic [OUT_BITS-1:0]   out_dev [CHANNELS];
  logic [COUNT_BITS-1:0] out_count;

  assign cfg_ready = 1'b1;

  assign pix.column = s_tdata[0 +: COORD_BITS];
  assign pix.row    = s_tdata[COORD_BITS +: COORD_BITS];
  assign pix.blue   = s_tdata[2 * COORD_BITS +: PIX_BITS];
  assign pix.green  = s_tdata[2 * COORD_BITS + PIX_BITS +: PIX_BITS];
  assign pix.red    = s_tdata[2 * COORD_BITS + 2 * PIX_BITS +: PIX_BITS];

  assign m_tdata = {(OUT_DATA_BITS - 6 * OUT_BITS - COUNT_BITS)'(0), out_count,
                    out_dev[2], out_dev[1], out_dev[0],
                    out_mean[2], out_mean[1], out_mean[0]};

  rcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rcs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix),
    .cmd       (cmd),
    .stat      (stat),
    .m_tready  (m_tready),
    .out_valid (m_tvalid),
    .out_mean  (out_mean),
    .out_dev   (out_dev),
    .out_count (out_count),
    .out_empty (m_tuser)
  );

endmodule

// File: tb/tb_region_color_statistics_core.sv
// Self-checking testbench for region_color_statistics_core: box statistics against a local model.
`timescale 1ns / 1ps

module tb_region_color_statistics_core;
  import rcs_pkg::*;

  typedef struct packed {
    logic                  region_empty;
    logic [COUNT_BITS-1:0] count;
    logic [5:0][15:0]      chan_stats;
  } frame_stats_t;

  class region_stats_board;
    logic [COORD_BITS-1:0] box_left, box_top;
    logic [SIZE_BITS-1:0]  box_width, box_height;
    longint unsigned       chan_sum[CHANNELS];
    longint unsigned       chan_sq[CHANNELS];
    longint unsigned       inside_n;
    frame_stats_t          pending[$];
    int                    errors;
    int                    results_seen;
    string stat_name[6] = '{"mean_blue", "mean_green", "mean_red",
                            "dev_blue", "dev_green", "dev_red"};

    function new();
      box_left = '0;
      box_top = '0;
      box_width = '0;
      box_height = '0;
      errors = 0;
      results_seen = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      for (int c = 0; c < CHANNELS; c++) begin
        chan_sum[c] = 0;
        chan_sq[c] = 0;
      end
      inside_n = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_BOX_LEFT: box_left = data[COORD_BITS-1:0];
        REG_BOX_TOP: box_top = data[COORD_BITS-1:0];
        REG_BOX_WIDTH: box_width = data;
        REG_BOX_HEIGHT: box_height = data;
        default: ;
      endcase
    endfunction

    function longint unsigned root_floor(longint unsigned x);
      longint unsigned res, bval;
      res = 0;
      bval = 64'h4000_0000_0000_0000;
      while (bval > x) bval >>= 2;
      while (bval != 0) begin
        if (x >= res + bval) begin
          x -= res + bval;
          res = (res >> 1) + bval;
        end else begin
          res >>= 1;
        end
        bval >>= 2;
      end
      return res;
    endfunction

    // floor(num * 2^(2*FRAC_BITS) / den)
    function longint unsigned frac_quotient(longint unsigned num, longint unsigned den);
      longint unsigned q, r;
      q = num / den;
      r = num % den;
      for (int i = 0; i < 2 * FRAC_BITS; i++) begin
        r <<= 1;
        q <<= 1;
        if (r >= den) begin
          r -= den;
          q |= 1;
        end
      end
      return q;
    endfunction

    function void note_pixel(pixel_t px, logic frame_end);
      longint unsigned chan[CHANNELS];
      longint unsigned n, d, mean, dev;
      frame_stats_t e;
      bit in_box;
      chan[0] = px.blue;
      chan[1] = px.green;
      chan[2] = px.red;
      in_box = px.column >= box_left && int'(px.column) < int'(box_left) + int'(box_width) &&
               px.row >= box_top && int'(px.row) < int'(box_top) + int'(box_height);
      if (in_box && inside_n < (64'd1 << CAP_BIT)) begin
        for (int c = 0; c < CHANNELS; c++) begin
          chan_sum[c] += chan[c];
          chan_sq[c] += chan[c] * chan[c];
        end
        inside_n++;
      end
      if (!frame_end) return;
      n = inside_n;
      for (int c = 0; c < CHANNELS; c++) begin
        mean = 0;
        dev = 0;
        if (n != 0) mean = (chan_sum[c] << FRAC_BITS) / n;
        if (n > 1) begin
          d = n * chan_sq[c] - chan_sum[c] * chan_sum[c];
          dev = root_floor(frac_quotient(d, n * (n - 1)));
        end
        e.chan_stats[c] = mean[15:0];
        e.chan_stats[CHANNELS+c] = dev[15:0];
      end
      e.count = n[COUNT_BITS-1:0];
      e.region_empty = (n == 0);
      pending.push_back(e);
      clear_sums();
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task check_result(logic [OUT_DATA_BITS-1:0] d, logic empty_flag);
      frame_stats_t e;
      results_seen++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d with none expected, tdata %h", results_seen, d));
        return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 6; i++)
        if (d[16*i +: 16] !== e.chan_stats[i])
          report($sformatf("result %0d %s got %h want %h", results_seen, stat_name[i],
                           d[16*i +: 16], e.chan_stats[i]));
      if (d[96 +: COUNT_BITS] !== e.count)
        report($sformatf("result %0d pixel_count got %0d want %0d", results_seen,
                         d[96 +: COUNT_BITS], e.count));
      if (empty_flag !== e.region_empty)
        report($sformatf("result %0d region_empty got %b want %b", results_seen,
                         empty_flag, e.region_empty));
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_DATA_BITS-1:0]   s_tdata = '0;
  logic                      s_tlast = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0]  m_tdata;
  logic                      m_tuser;

  region_stats_board board;
  int          burst_left = 0;
  int          pixels_sent = 0;
  logic [11:0] ready_tick = '0;

  region_color_statistics_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #10 clk = ~clk;

  // receiver: free-running, random, sparse and square-wave stall phases
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1'b1;
    case (ready_tick[11:10])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(0, 1));
      2'd2: m_tready <= (ready_tick[1:0] == 2'd0);
      default: m_tready <= ready_tick[3];
    endcase
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);

  task automatic send_pixel(logic [COORD_BITS-1:0] col, logic [COORD_BITS-1:0] row,
                            logic [7:0] b, logic [7:0] g, logic [7:0] r, logic frame_end);
    pixel_t px;
    int gap;
    px.column = col;
    px.row = row;
    px.blue = b;
    px.green = g;
    px.red = r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      burst_left = $urandom_range(1, 32);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {r, g, b, row, col};
    s_tlast <= frame_end;
    do @(posedge clk); while (!s_tready);
    board.note_pixel(px, frame_end);
    pixels_sent++;
  endtask

  task automatic write_cfg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
  endtask

  task automatic program_box(logic [CFG_DATA_BITS-1:0] left, logic [CFG_DATA_BITS-1:0] top,
                             logic [CFG_DATA_BITS-1:0] w, logic [CFG_DATA_BITS-1:0] h);
    if ($urandom_range(0, 1) == 0)
      write_cfg(CFG_INDEX_BITS'(REG_BOX_HEIGHT + 1 + $urandom_range(0, 3)),
                CFG_DATA_BITS'($urandom_range(0, 8191)));
    write_cfg(REG_BOX_LEFT, left);
    write_cfg(REG_BOX_TOP, top);
    write_cfg(REG_BOX_WIDTH, w);
    write_cfg(REG_BOX_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic new_box();
    logic [CFG_DATA_BITS-1:0] w, h;
    case ($urandom_range(0, 5))
      0: program_box(0, 0, 4096, 4096);
      1: begin
        w = CFG_DATA_BITS'($urandom_range(0, 4096));
        h = CFG_DATA_BITS'($urandom_range(0, 4096));
        if ($urandom_range(0, 1) == 0) w = 0;
        else h = 0;
        program_box(CFG_DATA_BITS'($urandom_range(0, 8191)),
                    CFG_DATA_BITS'($urandom_range(0, 8191)), w, h);
      end
      2: program_box(13'h0FFF | 13'($urandom_range(0, 1) << 12), 13'h1FFF, 4096, 4096);
      3: program_box(CFG_DATA_BITS'($urandom_range(0, 8191)),
                     CFG_DATA_BITS'($urandom_range(0, 8191)), 1, 1);
      default: begin
        w = ($urandom_range(0, 3) == 0) ? CFG_DATA_BITS'($urandom_range(0, 4096))
                                        : CFG_DATA_BITS'($urandom_range(1, 64));
        h = ($urandom_range(0, 3) == 0) ? CFG_DATA_BITS'($urandom_range(0, 4096))
                                        : CFG_DATA_BITS'($urandom_range(1, 64));
        program_box(CFG_DATA_BITS'($urandom_range(0, 8191)),
                    CFG_DATA_BITS'($urandom_range(0, 8191)), w, h);
      end
    endcase
  endtask

  // mostly near the box so that edges and interior are both hit
  function automatic logic [COORD_BITS-1:0] pick_coord(logic [COORD_BITS-1:0] base,
                                                        logic [SIZE_BITS-1:0] extent);
    int span, v;
    if ($urandom_range(0, 3) == 0) return COORD_BITS'($urandom_range(0, 4095));
    span = (extent > 48) ? 48 : int'(extent);
    v = int'(base) + int'($urandom_range(0, span + 3)) - 2;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int len;
    board = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // box still zero-sized after reset
    send_pixel(0, 0, 255, 255, 255, 1);
    wait_idle();
    program_box(0, 0, 4096, 4096);
    send_pixel(4095, 4095, 255, 0, 128, 1);
    send_pixel(0, 0, 0, 0, 0, 0);
    send_pixel(4095, 0, 255, 255, 255, 0);
    send_pixel(0, 4095, 0, 255, 0, 0);
    send_pixel(4095, 4095, 255, 0, 255, 1);
    wait_idle();
    program_box(13'h1FFF, 13'h1FFF, 1, 1);
    send_pixel(4095, 4095, 200, 100, 50, 0);
    send_pixel(4094, 4095, 1, 2, 3, 0);
    send_pixel(4095, 4094, 9, 9, 9, 1);
    wait_idle();
    program_box(100, 200, 0, 10);
    send_pixel(100, 200, 7, 8, 9, 0);
    send_pixel(100, 205, 70, 80, 90, 1);
    wait_idle();
    program_box(10, 10, 2, 2);
    send_pixel(10, 10, 0, 255, 17, 0);
    send_pixel(11, 10, 255, 0, 34, 0);
    send_pixel(10, 11, 255, 255, 51, 0);
    send_pixel(11, 11, 0, 0, 68, 0);
    send_pixel(12, 11, 99, 99, 99, 0);
    send_pixel(9, 10, 99, 99, 99, 0);
    send_pixel(11, 12, 99, 99, 99, 1);

    while (pixels_sent < 2000) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        new_box();
      end
      len = ($urandom_range(0, 4) == 0) ? 1 : int'($urandom_range(2, 40));
      for (int i = 0; i < len; i++)
        send_pixel(pick_coord(board.box_left, board.box_width),
                   pick_coord(board.box_top, board.box_height),
                   pick_sample(), pick_sample(), pick_sample(), i == len - 1);
    end
    s_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (900) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_region_color_statistics_core passed");
    end else begin
      $display("tb_region_color_statistics_core failed");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb_region_color_statistics_core failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rcs_pkg.sv
rtl/core/rcs_ctrl.sv
rtl/core/rcs_datapath.sv
rtl/core/region_color_statistics_core.sv
tb/tb_region_color_statistics_core.sv
